// ----- design/palt_pkg.sv -----
// Shared types, constants and codes for the palindromic tree builder.
package palt_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int ALPHA       = 26;
  localparam int NODE_CAP    = MAX_LEN + 2;
  localparam int TRANS_DEPTH = NODE_CAP * ALPHA;
  localparam int W           = 13;
  localparam int SYM_W       = 5;
  localparam int TA_W        = $clog2(TRANS_DEPTH);
  localparam logic [W-1:0] HIT_MAX   = 13'h1FFF;
  localparam logic [7:0]   BASE_RST  = 8'd97;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_ACCUM  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SYM = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_IDX = 2'd3
  } status_t;

  typedef struct packed {
    mode_t        mode;
    logic [7:0]   symbol;
    logic [W-1:0] node_index;
  } in_t;

  typedef struct packed {
    status_t      status;
    logic [W-1:0] suffix_node;
    logic [W-1:0] suffix_length;
    logic [W-1:0] chain_depth;
    logic [W-1:0] distinct_total;
    logic         created;
    logic [W-1:0] occurrences;
  } out_t;

  // One node entry of the node memory
  typedef struct packed {
    logic [W-1:0] len;
    logic [W-1:0] link;
    logic [W-1:0] hits;
    logic [W-1:0] chain;
  } node_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_WRD, S_WCHK, S_WSYM,
    S_TRD, S_TCHK,
    S_URD, S_UWR,
    S_LRD, S_NWR,
    S_ARD, S_ACHK, S_AWR,
    S_RCHK, S_DONE
  } state_t;

endpackage

// ----- design/palt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module palt_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/palindrome_tree_builder.sv -----
// Top level: eertree sequencer around node, symbol and transition memories.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_ready   | in_data  (mode, symbol, node_index)
//  out     | out | out_valid / out_ready | out_data (status ... occurrences)
//  cfg     | in  | cfg_valid / cfg_ready | cfg_data (base_symbol)
//
// Append: accept, transition read and check, node read and write, result when the
// node exists; when one is created, a second transition lookup, link read and node
// write; plus a node read and check (and a symbol check) for each node visited on
// each suffix-link walk; the pace is set by the single node-memory read port.
// Bad symbol or full text: straight to the result. Accumulate: for each node, read
// node, read parent, write parent. Read: a node read by index. Clear and reset: a
// sweep of all TRANS_DEPTH (106548) transition-memory entries with in_ready low;
// cfg writes are always taken.
// A finished beat waits in the output register while the next beat is accepted.
module palindrome_tree_builder (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  palt_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output palt_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data
);

  localparam int W     = palt_pkg::W;
  localparam int TA_W  = palt_pkg::TA_W;
  localparam int SYM_W = palt_pkg::SYM_W;

  palt_pkg::state_t state, state_next;

  // Control and datapath registers
  logic [7:0]       base_symbol;
  logic [TA_W-1:0]  cnt;
  logic             clr_cmd;
  logic [W-1:0]     tl;
  logic [W-1:0]     total;
  logic [W-1:0]     longest;
  logic [W-1:0]     long_len;
  logic [W-1:0]     long_chain;
  logic [SYM_W-1:0] d;
  logic [W-1:0]     x, xlen, xl;
  logic [W-1:0]     lenp, linkp;
  logic             second;
  logic [TA_W-1:0]  taddr_p;
  logic [W-1:0]     u_r, lk, t_r, hits_i, i_r, occ;
  palt_pkg::status_t status;
  logic             created;

  // Memory ports
  logic             node_we;
  logic [W-1:0]     node_waddr, node_raddr;
  palt_pkg::node_t  node_wdata, node_rd;
  logic             sym_we;
  logic [W-1:0]     sym_waddr, sym_raddr;
  logic [SYM_W-1:0] sym_wdata, sym_rd;
  logic             tr_we;
  logic [TA_W-1:0]  tr_waddr, tr_raddr;
  logic [W-1:0]     tr_wdata, tr_rd;

  palt_ram #(.DEPTH(palt_pkg::NODE_CAP), .WIDTH($bits(palt_pkg::node_t))) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rd)
  );

  palt_ram #(.DEPTH(palt_pkg::MAX_LEN + 1), .WIDTH(SYM_W)) u_sym (
    .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
    .raddr(sym_raddr), .rdata(sym_rd)
  );

  palt_ram #(.DEPTH(palt_pkg::TRANS_DEPTH), .WIDTH(W)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
    .raddr(tr_raddr), .rdata(tr_rd)
  );

  // Decode of the incoming beat
  logic [8:0]      diff;
  logic            sym_bad, txt_full, idx_ok;
  logic            in_fire;
  logic            at_root, pos_ok, sym_hit, clr_last, out_free;
  logic [TA_W-1:0] taddr_c;
  logic [W:0]      acc_sum;

  assign diff     = {1'b0, in_data.symbol} - {1'b0, base_symbol};
  assign sym_bad  = diff[8] || (diff[7:0] >= 8'(palt_pkg::ALPHA));
  assign txt_full = (tl == W'(palt_pkg::MAX_LEN));
  assign idx_ok   = (in_data.node_index < total);
  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state == palt_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Walk helpers: wrap test at position tl - len - 1, which must be at least 1
  assign at_root  = (x == W'(1));
  assign pos_ok   = ({1'b0, tl} >= ({1'b0, node_rd.len} + (W+1)'(2)));
  assign sym_hit  = (sym_rd == d);
  assign taddr_c  = TA_W'(x) * TA_W'(palt_pkg::ALPHA) + TA_W'(d);
  assign clr_last = (cnt == TA_W'(palt_pkg::TRANS_DEPTH - 1));
  assign out_free = !out_valid || out_ready;
  assign acc_sum  = {1'b0, node_rd.hits} + {1'b0, hits_i};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      palt_pkg::S_CLEAR: if (clr_last) begin
        state_next = clr_cmd ? palt_pkg::S_DONE : palt_pkg::S_IDLE;
      end
      palt_pkg::S_IDLE: if (in_valid) begin
        case (in_data.mode)
          palt_pkg::MODE_APPEND:
            state_next = (sym_bad || txt_full) ? palt_pkg::S_DONE : palt_pkg::S_WRD;
          palt_pkg::MODE_ACCUM:
            state_next = (total == W'(2)) ? palt_pkg::S_DONE : palt_pkg::S_ARD;
          palt_pkg::MODE_READ:
            state_next = idx_ok ? palt_pkg::S_RCHK : palt_pkg::S_DONE;
          default: state_next = palt_pkg::S_CLEAR;
        endcase
      end
      palt_pkg::S_WRD: state_next = palt_pkg::S_WCHK;
      palt_pkg::S_WCHK: begin
        if (at_root)     state_next = palt_pkg::S_TRD;
        else if (pos_ok) state_next = palt_pkg::S_WSYM;
        else             state_next = palt_pkg::S_WRD;
      end
      palt_pkg::S_WSYM: state_next = sym_hit ? palt_pkg::S_TRD : palt_pkg::S_WRD;
      palt_pkg::S_TRD:  state_next = palt_pkg::S_TCHK;
      palt_pkg::S_TCHK: begin
        if (second)            state_next = palt_pkg::S_LRD;
        else if (tr_rd != '0)  state_next = palt_pkg::S_URD;
        else                   state_next = palt_pkg::S_WRD;
      end
      palt_pkg::S_URD:  state_next = palt_pkg::S_UWR;
      palt_pkg::S_UWR:  state_next = palt_pkg::S_DONE;
      palt_pkg::S_LRD:  state_next = palt_pkg::S_NWR;
      palt_pkg::S_NWR:  state_next = palt_pkg::S_DONE;
      palt_pkg::S_ARD:  state_next = palt_pkg::S_ACHK;
      palt_pkg::S_ACHK: state_next = palt_pkg::S_AWR;
      palt_pkg::S_AWR:
        state_next = (i_r == W'(2)) ? palt_pkg::S_DONE : palt_pkg::S_ARD;
      palt_pkg::S_RCHK: state_next = palt_pkg::S_DONE;
      palt_pkg::S_DONE: if (out_free) state_next = palt_pkg::S_IDLE;
      default: state_next = palt_pkg::S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    node_we    = 1'b0;
    node_waddr = x;
    node_wdata = node_rd;
    node_raddr = x;
    sym_we     = 1'b0;
    sym_waddr  = tl + W'(1);
    sym_wdata  = diff[SYM_W-1:0];
    sym_raddr  = tl - node_rd.len - W'(1);
    tr_we      = 1'b0;
    tr_waddr   = taddr_p;
    tr_wdata   = total;
    tr_raddr   = taddr_c;
    case (state)
      palt_pkg::S_CLEAR: begin
        tr_we    = 1'b1;
        tr_waddr = cnt;
        tr_wdata = '0;
        node_we  = (cnt < TA_W'(palt_pkg::NODE_CAP));
        node_waddr = cnt[W-1:0];
        node_wdata = '0;
        node_wdata.len  = (cnt == TA_W'(1)) ? '1 : '0;
        node_wdata.link = (cnt < TA_W'(2)) ? W'(1) : '0;
      end
      palt_pkg::S_IDLE: begin
        node_raddr = in_data.node_index;
        sym_we = in_fire && (in_data.mode == palt_pkg::MODE_APPEND) && !sym_bad && !txt_full;
      end
      palt_pkg::S_URD:  node_raddr = u_r;
      palt_pkg::S_UWR: begin
        node_we    = 1'b1;
        node_waddr = u_r;
        node_wdata.hits = (node_rd.hits == palt_pkg::HIT_MAX) ? node_rd.hits
                                                              : node_rd.hits + W'(1);
      end
      palt_pkg::S_LRD:  node_raddr = lk;
      palt_pkg::S_NWR: begin
        node_we    = 1'b1;
        node_waddr = total;
        node_wdata.len   = lenp + W'(2);
        node_wdata.link  = lk;
        node_wdata.hits  = W'(1);
        node_wdata.chain = node_rd.chain + W'(1);
        tr_we = 1'b1;
      end
      palt_pkg::S_ARD:  node_raddr = i_r;
      palt_pkg::S_ACHK: node_raddr = node_rd.link;
      palt_pkg::S_AWR: begin
        node_we    = 1'b1;
        node_waddr = t_r;
        node_wdata.hits = (acc_sum > {1'b0, palt_pkg::HIT_MAX}) ? palt_pkg::HIT_MAX
                                                                : acc_sum[W-1:0];
      end
      default: ;
    endcase
  end

  // Datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= palt_pkg::S_CLEAR;
      base_symbol <= palt_pkg::BASE_RST;
      cnt         <= '0;
      clr_cmd     <= 1'b0;
      tl          <= '0;
      total       <= W'(2);
      longest     <= '0;
      long_len    <= '0;
      long_chain  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        base_symbol <= cfg_data;
      end
      // Drop the taken beat unless a new one is loaded this cycle
      if (out_valid && out_ready && (state != palt_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        palt_pkg::S_CLEAR: cnt <= cnt + TA_W'(1);
        palt_pkg::S_IDLE: if (in_fire) begin
          status  <= palt_pkg::ST_OK;
          created <= 1'b0;
          occ     <= '0;
          x       <= longest;
          second  <= 1'b0;
          d       <= diff[SYM_W-1:0];
          i_r     <= total - W'(1);
          case (in_data.mode)
            palt_pkg::MODE_APPEND: begin
              if (sym_bad)       status <= palt_pkg::ST_BAD_SYM;
              else if (txt_full) status <= palt_pkg::ST_FULL;
              else               tl     <= tl + W'(1);
            end
            palt_pkg::MODE_READ: if (!idx_ok) status <= palt_pkg::ST_BAD_IDX;
            palt_pkg::MODE_CLEAR: begin
              cnt        <= '0;
              clr_cmd    <= 1'b1;
              tl         <= '0;
              total      <= W'(2);
              longest    <= '0;
              long_len   <= '0;
              long_chain <= '0;
            end
            default: ;
          endcase
        end
        palt_pkg::S_WCHK: begin
          xlen <= node_rd.len;
          xl   <= node_rd.link;
          if (at_root) begin
            if (!second) begin
              lenp  <= node_rd.len;
              linkp <= node_rd.link;
            end
          end else if (!pos_ok) begin
            x <= node_rd.link;
          end
        end
        palt_pkg::S_WSYM: begin
          if (!sym_hit) begin
            x <= xl;
          end else if (!second) begin
            lenp  <= xlen;
            linkp <= xl;
          end
        end
        palt_pkg::S_TRD: if (!second) taddr_p <= taddr_c;
        palt_pkg::S_TCHK: begin
          if (second) begin
            lk <= tr_rd;
          end else if (tr_rd != '0) begin
            u_r <= tr_rd;
          end else begin
            second <= 1'b1;
            x      <= linkp;
          end
        end
        palt_pkg::S_UWR: begin
          longest    <= u_r;
          long_len   <= node_rd.len;
          long_chain <= node_rd.chain;
        end
        palt_pkg::S_NWR: begin
          longest    <= total;
          long_len   <= lenp + W'(2);
          long_chain <= node_rd.chain + W'(1);
          total      <= total + W'(1);
          created    <= 1'b1;
        end
        palt_pkg::S_ACHK: begin
          hits_i <= node_rd.hits;
          t_r    <= node_rd.link;
        end
        palt_pkg::S_AWR:  i_r <= i_r - W'(1);
        palt_pkg::S_RCHK: occ <= node_rd.hits;
        palt_pkg::S_DONE: if (out_free) begin
          out_valid               <= 1'b1;
          out_data.status         <= status;
          out_data.suffix_node    <= longest;
          out_data.suffix_length  <= long_len;
          out_data.chain_depth    <= long_chain;
          out_data.distinct_total <= total - W'(2);
          out_data.created        <= created;
          out_data.occurrences    <= occ;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- design/palt_checker.sv -----
// Port-level assertion checker for the palindromic tree builder, with its bind.
module palt_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input palt_pkg::out_t  out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // One item at a time: an accepted beat takes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken before the first finished");

  // Node creation only on a successful append
  a_created_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.created |-> out_data.status == palt_pkg::ST_OK &&
      out_data.occurrences == '0)
    else $error("created flag on a failed step");

endmodule

bind palindrome_tree_builder palt_checker u_palt_checker (.*);
